### hdl/assert_macros.svh
// Assertion macros used by the RTL of the motor mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i, switched off while rst_ni is low.
`define QXM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, written as antecedent and consequent in the same cycle.
`define QXM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/qxm_pkg.sv
// Types and constants of the quad X-frame motor mixer.
`timescale 1ns / 1ps
`default_nettype none
package qxm_pkg;

  localparam int unsigned CFG_W    = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TERM_W   = 50;  // signed Q.16 moment term
  localparam int unsigned MAG_W    = 49;
  localparam int unsigned SHARE_W  = 46;
  localparam int unsigned DVSR_W   = 50;
  localparam int unsigned QUOT_W   = 48;
  localparam int unsigned NUM_W    = MAG_W + SHARE_W;
  localparam int unsigned W2_W     = 40;
  localparam int unsigned ROOT_W   = 28;
  localparam int unsigned DRIVE_W  = 24;
  localparam int unsigned LIM_W    = 24;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned LANES    = 4;

  localparam int unsigned FE_LAT   = 5;
  localparam int unsigned LANE_LAT = QUOT_W + ROOT_W + 5;

  localparam logic [CFG_W-1:0]  RST_ROLL_PITCH_GAIN = 40'd89983418368;
  localparam logic [CFG_W-1:0]  RST_YAW_GAIN        = 40'd923795456000;
  localparam logic [CFG_W-1:0]  RST_THRUST_GAIN     = 40'd13997834240;
  localparam logic [LIM_W-1:0]  RST_SPEED_SQ_LIMIT  = 24'd5234944;
  localparam logic [COEF_W-1:0] RST_QUAD_COEFF      = 32'd115013000;
  localparam logic [COEF_W-1:0] RST_LIN_COEFF       = 32'd18642800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_PITCH_GAIN = 3'd0,
    CFG_YAW_GAIN        = 3'd1,
    CFG_THRUST_GAIN     = 3'd2,
    CFG_SPEED_SQ_LIMIT  = 3'd3,
    CFG_QUAD_COEFF      = 3'd4,
    CFG_LIN_COEFF       = 3'd5
  } cfg_idx_e;

  // One motor's word handed from the mixing front end to its lane.
  typedef struct packed {
    logic                     vld;
    logic                     desat;
    logic                     neg;
    logic signed [TERM_W-1:0] term;
    logic [MAG_W-1:0]         mag;
    logic [SHARE_W-1:0]       share;
    logic [DVSR_W-1:0]        dvsr;
  } lane_in_t;

endpackage
`default_nettype wire

### hdl/qxm_lane.sv
// One motor lane: desaturation divide, clamp, square root and drive voltage.
`timescale 1ns / 1ps
`default_nettype none
module qxm_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qxm_pkg::lane_in_t              lane_i,
  input  logic [qxm_pkg::W2_W-1:0]       cap_i,
  input  logic [qxm_pkg::COEF_W-1:0]     quad_coeff_i,
  input  logic [qxm_pkg::COEF_W-1:0]     lin_coeff_i,
  output logic                           valid_o,
  output logic [qxm_pkg::DRIVE_W-1:0]    drive_o
);
  import qxm_pkg::*;

  localparam int unsigned TOT_W = 77;

  typedef struct packed {
    logic                     vld;
    logic                     desat;
    logic                     neg;
    logic signed [TERM_W-1:0] term;
    logic [SHARE_W-1:0]       share;
    logic [DVSR_W-1:0]        dvsr;
    logic [DVSR_W-1:0]        rem;
    logic [QUOT_W-1:0]        low;
    logic [QUOT_W-1:0]        quot;
  } div_stage_t;

  typedef struct packed {
    logic              vld;
    logic [55:0]       x;
    logic [W2_W-1:0]   w2;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W+1:0] rem;
  } sqrt_stage_t;

  // partial products of |term| * share
  logic                  pp_vld_q;
  logic                  pp_desat_q, pp_neg_q;
  logic signed [TERM_W-1:0] pp_term_q;
  logic [SHARE_W-1:0]    pp_share_q;
  logic [DVSR_W-1:0]     pp_dvsr_q;
  logic [47:0]           p00_q, p01_q;
  logic [46:0]           p10_q, p11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else begin
      pp_vld_q <= lane_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_desat_q <= lane_i.desat;
    pp_neg_q   <= lane_i.neg;
    pp_term_q  <= lane_i.term;
    pp_share_q <= lane_i.share;
    pp_dvsr_q  <= lane_i.dvsr;
    p00_q <= 48'(lane_i.mag[24:0]) * 48'(lane_i.share[22:0]);
    p01_q <= 48'(lane_i.mag[24:0]) * 48'(lane_i.share[45:23]);
    p10_q <= 47'(lane_i.mag[48:25]) * 47'(lane_i.share[22:0]);
    p11_q <= 47'(lane_i.mag[48:25]) * 47'(lane_i.share[45:23]);
  end

  // dividend sum, loads the first divide stage
  logic [NUM_W-1:0] num;
  div_stage_t       dv_q [0:QUOT_W];
  div_stage_t       dv0_d;

  always_comb begin
    num = NUM_W'(p00_q) + (NUM_W'(p01_q) << 23) + (NUM_W'(p10_q) << 25)
        + (NUM_W'(p11_q) << 48);
    dv0_d       = '0;
    dv0_d.vld   = pp_vld_q;
    dv0_d.desat = pp_desat_q;
    dv0_d.neg   = pp_neg_q;
    dv0_d.term  = pp_term_q;
    dv0_d.share = pp_share_q;
    dv0_d.dvsr  = pp_dvsr_q;
    dv0_d.rem   = DVSR_W'(num[NUM_W-1:QUOT_W]);
    dv0_d.low   = num[QUOT_W-1:0];
    dv0_d.quot  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0].vld <= 1'b0;
    end else begin
      dv_q[0] <= dv0_d;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic [DVSR_W:0] trial;
    logic            ge;
    div_stage_t      dv_d;

    always_comb begin
      trial    = {dv_q[k].rem, dv_q[k].low[QUOT_W-1]};
      ge       = (trial >= {1'b0, dv_q[k].dvsr});
      dv_d     = dv_q[k];
      dv_d.low = {dv_q[k].low[QUOT_W-2:0], 1'b0};
      dv_d.quot = {dv_q[k].quot[QUOT_W-2:0], ge};
      dv_d.rem = ge ? DVSR_W'(trial - {1'b0, dv_q[k].dvsr}) : trial[DVSR_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1].vld <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_d;
      end
    end
  end

  // term (scaled when desaturating) plus share, clamped to [0, cap]
  logic signed [TERM_W-1:0] qs, s_sel;
  logic [TERM_W:0]          w2_sum;
  logic [W2_W-1:0]          w2;
  sqrt_stage_t              sq_q [0:ROOT_W];
  sqrt_stage_t              sq0_d;

  always_comb begin
    qs     = $signed({2'b00, dv_q[QUOT_W].quot});
    s_sel  = dv_q[QUOT_W].desat ? (dv_q[QUOT_W].neg ? -qs : qs) : dv_q[QUOT_W].term;
    w2_sum = {s_sel[TERM_W-1], s_sel} + {5'b0, dv_q[QUOT_W].share};
    if (w2_sum[TERM_W]) begin
      w2 = '0;
    end else if (w2_sum[TERM_W-1:0] > {10'b0, cap_i}) begin
      w2 = cap_i;
    end else begin
      w2 = w2_sum[W2_W-1:0];
    end
    sq0_d      = '0;
    sq0_d.vld  = dv_q[QUOT_W].vld;
    sq0_d.x    = {w2, 16'b0};
    sq0_d.w2   = w2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0].vld <= 1'b0;
    end else begin
      sq_q[0] <= sq0_d;
    end
  end

  // digit-by-digit root, two radicand bits per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] tv;
    logic              ge;
    sqrt_stage_t       sq_d;

    always_comb begin
      trial     = {sq_q[j].rem, sq_q[j].x[55:54]};
      tv        = {2'b00, sq_q[j].root, 2'b01};
      ge        = (trial >= tv);
      sq_d      = sq_q[j];
      sq_d.x    = {sq_q[j].x[53:0], 2'b00};
      sq_d.root = {sq_q[j].root[ROOT_W-2:0], ge};
      sq_d.rem  = ge ? (ROOT_W+2)'(trial - tv) : trial[ROOT_W+1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[j+1].vld <= 1'b0;
      end else begin
        sq_q[j+1] <= sq_d;
      end
    end
  end

  // drive products
  logic        dp_vld_q;
  logic [51:0] pq_lo_q, pq_hi_q;
  logic [59:0] pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_vld_q <= 1'b0;
    end else begin
      dp_vld_q <= sq_q[ROOT_W].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pq_lo_q <= 52'(quad_coeff_i) * 52'(sq_q[ROOT_W].w2[19:0]);
    pq_hi_q <= 52'(quad_coeff_i) * 52'(sq_q[ROOT_W].w2[39:20]);
    pl_q    <= 60'(lin_coeff_i) * 60'(sq_q[ROOT_W].root);
  end

  // sum at Q.64, take Q8.16 with saturation
  logic [TOT_W-1:0]   tot;
  logic [DRIVE_W-1:0] drive_d, drive_q;
  logic               out_vld_q;

  always_comb begin
    tot = TOT_W'(pq_lo_q) + (TOT_W'(pq_hi_q) << 20) + (TOT_W'(pl_q) << 16);
    drive_d = (|tot[TOT_W-1:72]) ? {DRIVE_W{1'b1}} : tot[71:48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
  end

  assign valid_o = out_vld_q;
  assign drive_o = drive_q;

endmodule
`default_nettype wire

### hdl/quad_x_motor_mixer_unit.sv
// Top level of the quad X-frame motor mixer with desaturation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Quad X-frame motor mixer. A command word (roll, pitch, yaw moments, body
// thrust) is taken at any clock edge where start is high; busy is always low,
// so a new word may follow every cycle. The four drive voltages come out
// together on the drive ports, marked by done_o for a single cycle; nothing
// holds them, so the receiver must take them then. The path runs through five
// mixing stages, then per-motor lanes with a 48-stage quotient pipeline (one
// bit per stage) for desaturation and a 28-stage square-root pipeline, with
// five lane stages around them. Throughput is one word per cycle.
// Configuration registers are written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i and act on words taken afterwards; write them only while no
// word is in flight. Indexes beyond the register list are ignored.
module quad_x_motor_mixer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [23:0]               moment_roll_i,
  input  logic signed [23:0]               moment_pitch_i,
  input  logic signed [23:0]               moment_yaw_i,
  input  logic [21:0]                      thrust_body_i,
  input  logic                             cfg_we_i,
  input  logic [qxm_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [qxm_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                             done_o,
  output logic [qxm_pkg::DRIVE_W-1:0]      drive_motor_a_o,
  output logic [qxm_pkg::DRIVE_W-1:0]      drive_motor_b_o,
  output logic [qxm_pkg::DRIVE_W-1:0]      drive_motor_c_o,
  output logic [qxm_pkg::DRIVE_W-1:0]      drive_motor_d_o
);
  import qxm_pkg::*;

  localparam int unsigned TOTAL_LAT = FE_LAT + LANE_LAT;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]  rp_gain_q, yaw_gain_q, thr_gain_q;
  logic [LIM_W-1:0]  limit_q;
  logic [COEF_W-1:0] quad_q, lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_gain_q  <= RST_ROLL_PITCH_GAIN;
      yaw_gain_q <= RST_YAW_GAIN;
      thr_gain_q <= RST_THRUST_GAIN;
      limit_q    <= RST_SPEED_SQ_LIMIT;
      quad_q     <= RST_QUAD_COEFF;
      lin_q      <= RST_LIN_COEFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_ROLL_PITCH_GAIN: rp_gain_q  <= cfg_wdata_i;
        CFG_YAW_GAIN:        yaw_gain_q <= cfg_wdata_i;
        CFG_THRUST_GAIN:     thr_gain_q <= cfg_wdata_i;
        CFG_SPEED_SQ_LIMIT:  limit_q    <= cfg_wdata_i[LIM_W-1:0];
        CFG_QUAD_COEFF:      quad_q     <= cfg_wdata_i[COEF_W-1:0];
        CFG_LIN_COEFF:       lin_q      <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Never stalls: the pipeline takes a word every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Stage 1: roll/pitch sum and difference, sign-magnitude split
  // ---------------------------------------------------------------------
  logic [24:0] sab, dab, mag_a_d, mag_b_d;
  logic [23:0] mag_y_d;

  always_comb begin
    sab = {moment_roll_i[23], moment_roll_i} + {moment_pitch_i[23], moment_pitch_i};
    dab = {moment_pitch_i[23], moment_pitch_i} - {moment_roll_i[23], moment_roll_i};
    mag_a_d = sab[24] ? (~sab + 25'd1) : sab;
    mag_b_d = dab[24] ? (~dab + 25'd1) : dab;
    mag_y_d = moment_yaw_i[23] ? (~moment_yaw_i + 24'd1) : moment_yaw_i;
  end

  logic        s1_vld_q;
  logic        s1_na_q, s1_nb_q, s1_ny_q;
  logic [24:0] s1_ma_q, s1_mb_q;
  logic [23:0] s1_my_q;
  logic [21:0] s1_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_na_q <= sab[24];
    s1_nb_q <= dab[24];
    s1_ny_q <= moment_yaw_i[23];
    s1_ma_q <= mag_a_d;
    s1_mb_q <= mag_b_d;
    s1_my_q <= mag_y_d;
    s1_th_q <= thrust_body_i;
  end

  // ---------------------------------------------------------------------
  // Stage 2: partial products against 20-bit halves of each gain
  // ---------------------------------------------------------------------
  logic        s2_vld_q, s2_na_q, s2_nb_q, s2_ny_q;
  logic [44:0] pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;
  logic [43:0] py_lo_q, py_hi_q;
  logic [41:0] ps_lo_q, ps_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_na_q <= s1_na_q;
    s2_nb_q <= s1_nb_q;
    s2_ny_q <= s1_ny_q;
    pa_lo_q <= 45'(s1_ma_q) * 45'(rp_gain_q[19:0]);
    pa_hi_q <= 45'(s1_ma_q) * 45'(rp_gain_q[39:20]);
    pb_lo_q <= 45'(s1_mb_q) * 45'(rp_gain_q[19:0]);
    pb_hi_q <= 45'(s1_mb_q) * 45'(rp_gain_q[39:20]);
    py_lo_q <= 44'(s1_my_q) * 44'(yaw_gain_q[19:0]);
    py_hi_q <= 44'(s1_my_q) * 44'(yaw_gain_q[39:20]);
    ps_lo_q <= 42'(s1_th_q) * 42'(thr_gain_q[19:0]);
    ps_hi_q <= 42'(s1_th_q) * 42'(thr_gain_q[39:20]);
  end

  // ---------------------------------------------------------------------
  // Stage 3: recombine, drop 16 fraction bits, restore sign
  // ---------------------------------------------------------------------
  logic [64:0] fa, fb;
  logic [63:0] fy;
  logic [61:0] fs;
  logic signed [TERM_W-1:0] ua, ub, uy, a_d, b_d, y_d;

  always_comb begin
    fa  = (65'(pa_hi_q) << 20) + 65'(pa_lo_q);
    fb  = (65'(pb_hi_q) << 20) + 65'(pb_lo_q);
    fy  = (64'(py_hi_q) << 20) + 64'(py_lo_q);
    fs  = (62'(ps_hi_q) << 20) + 62'(ps_lo_q);
    ua  = $signed({2'b00, fa[63:16]});
    ub  = $signed({2'b00, fb[63:16]});
    uy  = $signed({3'b000, fy[62:16]});
    a_d = s2_na_q ? -ua : ua;
    b_d = s2_nb_q ? -ub : ub;
    y_d = s2_ny_q ? -uy : uy;
  end

  logic                     s3_vld_q;
  logic signed [TERM_W-1:0] s3_a_q, s3_b_q, s3_y_q;
  logic [SHARE_W-1:0]       s3_share_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_a_q     <= a_d;
    s3_b_q     <= b_d;
    s3_y_q     <= y_d;
    s3_share_q <= fs[61:16];
  end

  // ---------------------------------------------------------------------
  // Stage 4: X-frame mix, signs (+,+,-) (-,+,+) (-,-,-) (+,-,+)
  // ---------------------------------------------------------------------
  logic                     s4_vld_q;
  logic signed [TERM_W-1:0] s4_t_q [LANES];
  logic [SHARE_W-1:0]       s4_share_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_t_q[0]  <= s3_a_q - s3_y_q;
    s4_t_q[1]  <= s3_b_q + s3_y_q;
    s4_t_q[2]  <= -s3_a_q - s3_y_q;
    s4_t_q[3]  <= -s3_b_q + s3_y_q;
    s4_share_q <= s3_share_q;
  end

  // ---------------------------------------------------------------------
  // Stage 5: most negative term, desaturation flag and divisor |min|+1
  // ---------------------------------------------------------------------
  logic signed [TERM_W-1:0] mn01, mn23, mn, neg_mn;
  logic                     desat;
  logic [DVSR_W-1:0]        dvsr;
  lane_in_t                 lane_d [LANES];
  lane_in_t                 lane_q [LANES];

  always_comb begin
    mn01   = (s4_t_q[1] < s4_t_q[0]) ? s4_t_q[1] : s4_t_q[0];
    mn23   = (s4_t_q[3] < s4_t_q[2]) ? s4_t_q[3] : s4_t_q[2];
    mn     = (mn23 < mn01) ? mn23 : mn01;
    neg_mn = -mn;
    desat  = mn[TERM_W-1] && ($unsigned(neg_mn) > {4'b0, s4_share_q});
    dvsr   = $unsigned(neg_mn) + DVSR_W'(1);
    for (int i = 0; i < LANES; i++) begin
      lane_d[i].vld   = s4_vld_q;
      lane_d[i].desat = desat;
      lane_d[i].neg   = s4_t_q[i][TERM_W-1];
      lane_d[i].term  = s4_t_q[i];
      lane_d[i].mag   = s4_t_q[i][TERM_W-1] ? MAG_W'(-s4_t_q[i])
                                            : s4_t_q[i][MAG_W-1:0];
      lane_d[i].share = s4_share_q;
      lane_d[i].dvsr  = dvsr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        lane_q[i].vld <= 1'b0;
      end
    end else begin
      lane_q <= lane_d;
    end
  end

  // ---------------------------------------------------------------------
  // Per-motor lanes
  // ---------------------------------------------------------------------
  logic [W2_W-1:0]    cap;
  logic [LANES-1:0]   lane_vld;
  logic [DRIVE_W-1:0] lane_drive [LANES];

  assign cap = {limit_q, 16'b0};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    qxm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .lane_i       (lane_q[g]),
      .cap_i        (cap),
      .quad_coeff_i (quad_q),
      .lin_coeff_i  (lin_q),
      .valid_o      (lane_vld[g]),
      .drive_o      (lane_drive[g])
    );
  end

  assign done_o          = &lane_vld;
  assign drive_motor_a_o = lane_drive[0];
  assign drive_motor_b_o = lane_drive[1];
  assign drive_motor_c_o = lane_drive[2];
  assign drive_motor_d_o = lane_drive[3];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `QXM_ASSERT(a_lat_fwd, accept |-> ##TOTAL_LAT done_o, "word accepted but no result")
  `QXM_ASSERT(a_lat_back, done_o |-> $past(accept, TOTAL_LAT), "result without a word")
  `QXM_ASSERT_IMPL(a_lanes_agree, |lane_vld, &lane_vld, "motor lanes out of step")

endmodule
`default_nettype wire
